[rtl/pngstrip_pkg.sv]
// Shared types and constants for the PNG ancillary chunk stripper.
package pngstrip_pkg;

	localparam int QDepth = 4;
	localparam int QPtrW  = $clog2(QDepth);

	localparam logic [7:0]  SigByte0 = 8'h89;
	localparam logic [7:0]  SigByte1 = 8'h50; // P
	localparam logic [7:0]  SigByte2 = 8'h4E; // N
	localparam logic [7:0]  SigByte3 = 8'h47; // G
	localparam logic [31:0] TypeIhdr = 32'h4948_4452;
	localparam logic [31:0] TypePlte = 32'h504C_5445;
	localparam logic [31:0] TypeIdat = 32'h4944_4154;
	localparam logic [31:0] TypeIend = 32'h4945_4E44;
	localparam logic [31:0] CrcLen   = 32'd4;

	typedef enum logic [2:0] {
		PH_SIG   = 3'd0,
		PH_HDR   = 3'd1,
		PH_CHEAD = 3'd2,
		PH_BODY  = 3'd3,
		PH_DROP  = 3'd4
	} phase_t;

	// one queue entry: up to eight bytes to send, plus the end-of-stream mark
	typedef struct packed {
		logic [7:0][7:0] data;
		logic [3:0]      cnt;
		logic            last;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} qhead_t;

endpackage

[rtl/pngstrip_front.sv]
// Front end: byte intake, signature check, chunk header parse and keep decision.
module pngstrip_front import pngstrip_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	input  logic       full,
	output logic       push,
	output cmd_t       cmd
);

	phase_t          phase_q, phase_nxt;
	logic [2:0]      hc_q, hc_nxt;
	logic [7:0][7:0] hb_q;
	logic [31:0]     br_q, br_nxt;
	logic            keep_q, keep_nxt;

	logic            accept;
	logic [2:0]      pos;
	logic [7:0][7:0] grp;
	logic            sig_ok;
	logic            type_ok;
	logic [31:0]     len;
	logic [31:0]     type_word;

	assign in_stall = full;
	assign accept   = in_valid && !full;

	assign pos = (phase_q == PH_SIG) ? {1'b0, hc_q[1:0]} : hc_q;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			grp[i] = (pos == 3'(i)) ? in_byte : hb_q[i];
		end
	end

	assign sig_ok = grp[0] == SigByte0 && grp[1] == SigByte1 &&
	                grp[2] == SigByte2 && grp[3] == SigByte3;
	assign len       = {grp[0], grp[1], grp[2], grp[3]};
	assign type_word = {grp[4], grp[5], grp[6], grp[7]};
	assign type_ok   = type_word == TypeIhdr || type_word == TypePlte ||
	                   type_word == TypeIdat || type_word == TypeIend;

	// next state
	always_comb begin
		phase_nxt = phase_q;
		hc_nxt    = hc_q;
		br_nxt    = br_q;
		keep_nxt  = keep_q;
		unique case (phase_q)
			PH_SIG: begin
				hc_nxt = hc_q + 3'd1;
				if (hc_q == 3'd3) begin
					if (sig_ok) begin
						phase_nxt = PH_HDR;
					end else begin
						phase_nxt = PH_DROP;
						hc_nxt    = 3'd0;
					end
				end
			end
			PH_HDR: begin
				hc_nxt = hc_q + 3'd1;
				if (hc_q == 3'd7) phase_nxt = PH_CHEAD;
			end
			PH_CHEAD: begin
				hc_nxt = hc_q + 3'd1;
				if (hc_q == 3'd7) begin
					// negative length reads as zero: only the CRC follows
					br_nxt    = (len[31] ? 32'd0 : len) + CrcLen;
					keep_nxt  = type_ok;
					phase_nxt = PH_BODY;
				end
			end
			PH_BODY: begin
				br_nxt = br_q - 32'd1;
				if (br_q == 32'd1) begin
					phase_nxt = PH_CHEAD;
					hc_nxt    = 3'd0;
					keep_nxt  = 1'b0;
				end
			end
			default: ;
		endcase
		if (in_last) begin
			phase_nxt = PH_SIG;
			hc_nxt    = 3'd0;
			br_nxt    = 32'd0;
			keep_nxt  = 1'b0;
		end
	end

	// queue word
	always_comb begin
		cmd.data = '0;
		cmd.cnt  = 4'd0;
		cmd.last = in_last;
		unique case (phase_q)
			PH_SIG: begin
				if (hc_q == 3'd3 && sig_ok) begin
					cmd.data = grp;
					cmd.cnt  = 4'd4;
				end
			end
			PH_HDR: begin
				cmd.data[0] = in_byte;
				cmd.cnt     = 4'd1;
			end
			PH_CHEAD: begin
				if (hc_q == 3'd7 && type_ok) begin
					cmd.data = grp;
					cmd.cnt  = 4'd8;
				end
			end
			PH_BODY: begin
				if (keep_q) begin
					cmd.data[0] = in_byte;
					cmd.cnt     = 4'd1;
				end
			end
			default: ;
		endcase
		push = accept && (cmd.cnt != 4'd0 || in_last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SIG;
			hc_q    <= 3'd0;
			br_q    <= 32'd0;
			keep_q  <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_nxt;
			hc_q    <= hc_nxt;
			br_q    <= br_nxt;
			keep_q  <= keep_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (phase_q == PH_SIG || phase_q == PH_CHEAD)) hb_q <= grp;
	end

endmodule

[rtl/pngstrip_fifo.sv]
// Small command queue between front and back end.
module pngstrip_fifo import pngstrip_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  cmd_t   wdata,
	output logic   full,
	input  logic   pop,
	output qhead_t head
);

	cmd_t             mem [QDepth];
	logic [QPtrW-1:0] wp_q, rp_q;
	logic [QPtrW:0]   cnt_q;

	assign full       = cnt_q == (QPtrW+1)'(QDepth);
	assign head.valid = cnt_q != '0;
	assign head.cmd   = mem[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

[rtl/pngstrip_back.sv]
// Back end: unpacks queue words into single output bytes behind an output register.
module pngstrip_back import pngstrip_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  qhead_t     head,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       has_byte,
	output logic       out_last
);

	logic [2:0] idx_q;
	logic       ov_q;
	logic       load;
	logic       final_one;

	assign load      = head.valid && (!ov_q || !out_stall);
	assign final_one = head.cmd.cnt == 4'd0 || {1'b0, idx_q} == head.cmd.cnt - 4'd1;
	assign pop       = load && final_one;
	assign out_valid = ov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q  <= 1'b0;
			idx_q <= 3'd0;
		end else begin
			if (load) ov_q <= 1'b1;
			else if (!out_stall) ov_q <= 1'b0;
			if (load) idx_q <= final_one ? 3'd0 : idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte <= (head.cmd.cnt == 4'd0) ? 8'd0 : head.cmd.data[idx_q];
			has_byte <= head.cmd.cnt != 4'd0;
			out_last <= head.cmd.last && final_one;
		end
	end

endmodule

[rtl/png_ancillary_chunk_stripper_top.sv]
// Top level of the PNG ancillary chunk stripper.
//  channel | dir | handshake           | payload
//  in      | in  | in_valid/in_stall   | in_byte, in_last
//  out     | out | out_valid/out_stall | out_byte, has_byte, out_last
// One input byte per cycle is taken while the 4-entry queue has room.
// Unless out_stall holds it, the back end sends one result per cycle; a kept
// chunk header gives an 8-byte burst and the signature a 4-byte burst, which
// the queue absorbs.
// Reset clears all control state at once; no clearing pass is needed.
// in_stall rises only when the queue is full.
module png_ancillary_chunk_stripper_top import pngstrip_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       has_byte,
	output logic       out_last
);

	logic   push, full, pop;
	cmd_t   cmd;
	qhead_t head;

	pngstrip_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.full     (full),
		.push     (push),
		.cmd      (cmd)
	);

	pngstrip_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cmd),
		.full   (full),
		.pop    (pop),
		.head   (head)
	);

	pngstrip_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.has_byte  (has_byte),
		.out_last  (out_last)
	);

	a_bare_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_byte |-> out_last && out_byte == 8'd0)
		else $error("bare result without end mark");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid)
		else $error("pop from empty queue");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");

endmodule
